### rtl/core/fpa_pkg.sv
// Shared types and operation codes for the fixed-point ALU.
// No dependencies; used by every module in rtl/core.
package fpa_pkg;

	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_GT  = 4'd4;
	localparam logic [3:0] FN_LT  = 4'd5;
	localparam logic [3:0] FN_GE  = 4'd6;
	localparam logic [3:0] FN_LE  = 4'd7;
	localparam logic [3:0] FN_EQ  = 4'd8;
	localparam logic [3:0] FN_NE  = 4'd9;
	localparam logic [3:0] FN_MIN = 4'd10;
	localparam logic [3:0] FN_MAX = 4'd11;
	localparam logic [3:0] FN_INC = 4'd12;
	localparam logic [3:0] FN_DEC = 4'd13;
	localparam logic [3:0] FN_INT = 4'd14;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_word;
		logic               compare_true;
		logic               divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic [3:0]         func;
		logic [31:0]        simple;
		logic               cmp;
		logic signed [63:0] prod;
		logic               neg;
		logic               dz;
	} side_t;

endpackage

### rtl/core/fpa_prep.sv
// Input register and operand stage: simple ops, product, divider setup.
// Depends on fpa_pkg.
module fpa_prep import fpa_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 8,
	parameter int NW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  req_t          req,
	input  logic          take_next,
	output logic          v_s2,
	output side_t         side_s2,
	output logic [NW-1:0] num_s2,
	output logic [W-1:0]  den_s2
);

	logic              v_s1;
	logic [3:0]        func_s1;
	logic signed [31:0] a_s1, b_s1;
	logic              take_s1, take_s2;
	logic signed [31:0] a_ext, b_ext;
	logic [31:0]       simple;
	logic              cmp;
	logic [31:0]       ma, mb;

	assign take_s2   = !v_s2 || take_next;
	assign take_s1   = !v_s1 || take_s2;
	assign req_stall = !take_s1;

	assign a_ext = $signed(32'(req.operand_a) << (32 - W)) >>> (32 - W);
	assign b_ext = $signed(32'(req.operand_b) << (32 - W)) >>> (32 - W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			func_s1 <= req.func;
			a_s1    <= a_ext;
			b_s1    <= b_ext;
		end
	end

	always_comb begin
		simple = '0;
		cmp    = 1'b0;
		unique case (func_s1)
			FN_ADD: simple = 32'(a_s1 + b_s1);
			FN_SUB: simple = 32'(a_s1 - b_s1);
			FN_GT:  cmp = a_s1 > b_s1;
			FN_LT:  cmp = a_s1 < b_s1;
			FN_GE:  cmp = a_s1 >= b_s1;
			FN_LE:  cmp = a_s1 <= b_s1;
			FN_EQ:  cmp = a_s1 == b_s1;
			FN_NE:  cmp = a_s1 != b_s1;
			FN_MIN: simple = (a_s1 < b_s1) ? a_s1 : b_s1;
			FN_MAX: simple = (a_s1 > b_s1) ? a_s1 : b_s1;
			FN_INC: simple = 32'(a_s1 + 32'sd1);
			FN_DEC: simple = 32'(a_s1 - 32'sd1);
			FN_INT: simple = a_s1 >>> F;
			default: simple = '0;
		endcase
	end

	assign ma = a_s1[31] ? 32'(-a_s1) : a_s1;
	assign mb = b_s1[31] ? 32'(-b_s1) : b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			side_s2.func   <= func_s1;
			side_s2.simple <= simple;
			side_s2.cmp    <= cmp;
			side_s2.prod   <= 64'(a_s1) * 64'(b_s1);
			side_s2.neg    <= a_s1[31] ^ b_s1[31];
			side_s2.dz     <= (func_s1 == FN_DIV) && (b_s1 == 32'sd0);
			num_s2         <= NW'(ma[W-1:0]) << F;
			den_s2         <= mb[W-1:0];
		end
	end

endmodule

### rtl/core/fpa_div_step.sv
// One restoring division step: one quotient bit per stage, sideband carried along.
// Depends on fpa_pkg.
module fpa_div_step import fpa_pkg::*; #(
	parameter int W  = 32,
	parameter int NW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  side_t         side_in,
	input  logic [W-1:0]  rem_in,
	input  logic [NW-1:0] num_in,
	input  logic [NW-1:0] q_in,
	input  logic [W-1:0]  den_in,
	input  logic          take_next,
	output logic          take,
	output logic          v_sd,
	output side_t         side_sd,
	output logic [W-1:0]  rem_sd,
	output logic [NW-1:0] num_sd,
	output logic [NW-1:0] q_sd,
	output logic [W-1:0]  den_sd
);

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	assign take  = !v_sd || take_next;
	assign trial = {rem_in, num_in[NW-1]};
	assign ge    = trial >= {1'b0, den_in};
	assign diff  = trial - {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (take) begin
			v_sd <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			side_sd <= side_in;
			rem_sd  <= ge ? diff[W-1:0] : trial[W-1:0];
			num_sd  <= num_in << 1;
			q_sd    <= {q_in[NW-2:0], ge};
			den_sd  <= den_in;
		end
	end

endmodule

### rtl/core/fpa_finish.sv
// Output stage: quotient rounding and sign, result select, wrap to the word width.
// Depends on fpa_pkg.
module fpa_finish import fpa_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 8,
	parameter int NW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  side_t         side_in,
	input  logic [W-1:0]  rem_in,
	input  logic [NW-1:0] q_in,
	input  logic [W-1:0]  den_in,
	output logic          take,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsp_t          rsp
);

	logic [NW-1:0] q_rnd;
	logic [NW-1:0] q_sgn;
	logic [W-1:0]  res;
	logic          up;

	assign take  = !rsp_valid || !rsp_stall;
	assign up    = {rem_in, 1'b0} >= {1'b0, den_in};
	assign q_rnd = q_in + NW'(up);
	assign q_sgn = side_in.neg ? NW'(-q_rnd) : q_rnd;

	always_comb begin
		unique case (side_in.func)
			FN_MUL:  res = side_in.prod[F +: W];
			FN_DIV:  res = side_in.dz ? '0 : q_sgn[W-1:0];
			default: res = side_in.simple[W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (take) begin
			rsp_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp.result_word    <= $signed(32'(res) << (32 - W)) >>> (32 - W);
			rsp.compare_true   <= side_in.cmp;
			rsp.divide_by_zero <= side_in.dz;
		end
	end

endmodule

### rtl/core/fixed_point_alu.sv
// Fixed-point ALU, fully pipelined: one request per cycle while rsp_stall is low.
// Requests pass the prep stage, a restoring divider step per stage, then the output stage.
// All functions share one pipe, so results leave in request order.
// Reset (arst_n low) clears every stage valid bit; no data is held over.
// Depends on fpa_pkg, fpa_prep, fpa_div_step, fpa_finish.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int W  = DATA_WIDTH;
	localparam int NW = DATA_WIDTH + FRAC_BITS;

	logic          v_c    [NW+1];
	side_t         side_c [NW+1];
	logic [W-1:0]  rem_c  [NW+1];
	logic [NW-1:0] num_c  [NW+1];
	logic [NW-1:0] q_c    [NW+1];
	logic [W-1:0]  den_c  [NW+1];
	logic          take_c [NW+1];

	assign rem_c[0] = '0;
	assign q_c[0]   = '0;

	fpa_prep #(.W(W), .F(FRAC_BITS), .NW(NW)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.take_next (take_c[0]),
		.v_s2      (v_c[0]),
		.side_s2   (side_c[0]),
		.num_s2    (num_c[0]),
		.den_s2    (den_c[0])
	);

	for (genvar k = 0; k < NW; k++) begin : g_div
		fpa_div_step #(.W(W), .NW(NW)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.v_in      (v_c[k]),
			.side_in   (side_c[k]),
			.rem_in    (rem_c[k]),
			.num_in    (num_c[k]),
			.q_in      (q_c[k]),
			.den_in    (den_c[k]),
			.take_next (take_c[k+1]),
			.take      (take_c[k]),
			.v_sd      (v_c[k+1]),
			.side_sd   (side_c[k+1]),
			.rem_sd    (rem_c[k+1]),
			.num_sd    (num_c[k+1]),
			.q_sd      (q_c[k+1]),
			.den_sd    (den_c[k+1])
		);
	end

	fpa_finish #(.W(W), .F(FRAC_BITS), .NW(NW)) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_c[NW]),
		.side_in   (side_c[NW]),
		.rem_in    (rem_c[NW]),
		.q_in      (q_c[NW]),
		.den_in    (den_c[NW]),
		.take      (take_c[NW]),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.result_word == 32'sd0)
		else $error("divide by zero with nonzero result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.compare_true |-> rsp.result_word == 32'sd0)
		else $error("comparison with nonzero result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.compare_true && rsp.divide_by_zero))
		else $error("compare and divide flags both set");

	a_empty_out_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled while output register empty");

endmodule
